>>> hdl/heading_aware_acceleration_limiter_unit_defines.svh
// Assertion helpers for the limiter
`ifndef HEADING_AWARE_ACCELERATION_LIMITER_UNIT_DEFINES_SVH
`define HEADING_AWARE_ACCELERATION_LIMITER_UNIT_DEFINES_SVH

`define HAL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define HAL_ASSERT_LAT(label, clk, rstn, ante, lat, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> ##lat (cons)) \
        else $error(msg);

`endif

>>> hdl/hal_pkg.sv
package hal_pkg;

    localparam logic [7:0] CFG_SIDE_ACC = 8'd0;
    localparam logic [7:0] CFG_FWD_ACC  = 8'd1;
    localparam logic [7:0] CFG_SIDE_DEC = 8'd2;
    localparam logic [7:0] CFG_FWD_DEC  = 8'd3;

    localparam int VEC_W    = 28;
    localparam int ROT_W    = 34;
    localparam logic signed [ROT_W-1:0] CORDIC_START_X = 34'sd652032874;

    localparam int SQ_STEPS = 25;
    localparam int SQ_IN_W  = 2 * SQ_STEPS;
    localparam int SQ_REM_W = SQ_STEPS + 2;

    localparam int LEN_W     = SQ_STEPS;
    localparam int Q_W       = 16;
    localparam int NUM_W     = 40;

    typedef struct packed {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [15:0]        hd;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [15:0] p;
        logic [15:0]        b;
        logic [15:0]        a;
        logic [31:0]        sqx;
        logic [31:0]        sqy;
        logic [32:0]        d2;
        logic [14:0]        fin;
        logic [30:0]        magx;
        logic [30:0]        magy;
        logic               pass;
        logic               d2z;
        logic [LEN_W-1:0]   len;
    } t_item;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933405;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10680862;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335086;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41721;
            15: v = 32'd20860;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2607;
            19: v = 32'd1303;
            20: v = 32'd651;
            21: v = 32'd325;
            22: v = 32'd162;
            23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/hal_vec_cordic.sv
module hal_vec_cordic #(
    parameter int ITER = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hal_pkg::t_item     i_item,
    input  logic signed [16:0] i_ax,
    input  logic signed [16:0] i_ay,
    input  logic signed [16:0] i_bx,
    input  logic signed [16:0] i_by,
    output logic               o_valid,
    output hal_pkg::t_item     o_item,
    output logic [15:0]        o_ang_a,
    output logic [15:0]        o_ang_b
);
    localparam int W = hal_pkg::VEC_W;

    logic signed [W-1:0] r_x    [0:ITER][0:1];
    logic signed [W-1:0] r_y    [0:ITER][0:1];
    logic [31:0]         r_z    [0:ITER][0:1];
    logic                r_zero [0:ITER][0:1];
    logic                r_v    [0:ITER+1];
    hal_pkg::t_item      r_item [0:ITER+1];
    logic [15:0]         r_ang  [0:1];
    logic signed [16:0]  w_ix   [0:1];
    logic signed [16:0]  w_iy   [0:1];

    assign w_ix[0] = i_ax;
    assign w_iy[0] = i_ay;
    assign w_ix[1] = i_bx;
    assign w_iy[1] = i_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ITER + 1; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= ITER + 1; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_item[0] <= i_item;
        for (int k = 1; k <= ITER + 1; k++) r_item[k] <= r_item[k-1];
    end

    generate
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic signed [W-1:0] w_x0;
            logic signed [W-1:0] w_y0;
            logic [31:0]         w_round;

            assign w_x0    = {{(W-25){w_ix[l][16]}}, w_ix[l], 8'h00};
            assign w_y0    = {{(W-25){w_iy[l][16]}}, w_iy[l], 8'h00};
            assign w_round = r_z[ITER][l] + 32'h0000_8000;

            // fold the left half plane onto the right
            always_ff @(posedge i_clk) begin
                if (w_x0[W-1]) begin
                    r_x[0][l] <= -w_x0;
                    r_y[0][l] <= -w_y0;
                    r_z[0][l] <= 32'h8000_0000;
                end else begin
                    r_x[0][l] <= w_x0;
                    r_y[0][l] <= w_y0;
                    r_z[0][l] <= 32'h0000_0000;
                end
                r_zero[0][l] <= (w_ix[l] == 17'sd0) && (w_iy[l] == 17'sd0);
            end

            for (genvar k = 0; k < ITER; k++) begin : g_it
                always_ff @(posedge i_clk) begin
                    if (!r_y[k][l][W-1] && (r_y[k][l] != '0)) begin
                        r_x[k+1][l] <= r_x[k][l] + (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] - (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] + hal_pkg::atan_turn(k);
                    end else begin
                        r_x[k+1][l] <= r_x[k][l] - (r_y[k][l] >>> k);
                        r_y[k+1][l] <= r_y[k][l] + (r_x[k][l] >>> k);
                        r_z[k+1][l] <= r_z[k][l] - hal_pkg::atan_turn(k);
                    end
                    r_zero[k+1][l] <= r_zero[k][l];
                end
            end

            always_ff @(posedge i_clk) begin
                r_ang[l] <= r_zero[ITER][l] ? 16'h0000 : w_round[31:16];
            end
        end
    endgenerate

    assign o_valid = r_v[ITER+1];
    assign o_item  = r_item[ITER+1];
    assign o_ang_a = r_ang[0];
    assign o_ang_b = r_ang[1];

endmodule

>>> hdl/hal_rot_cordic.sv
module hal_rot_cordic #(
    parameter int ITER = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hal_pkg::t_item     i_item,
    input  logic signed [15:0] i_p,
    output logic               o_valid,
    output hal_pkg::t_item     o_item,
    output logic [15:0]        o_cos
);
    localparam int W = hal_pkg::ROT_W;

    logic signed [W-1:0] r_x    [0:ITER];
    logic signed [W-1:0] r_y    [0:ITER];
    logic signed [W-1:0] r_z    [0:ITER];
    logic                r_v    [0:ITER+1];
    hal_pkg::t_item      r_item [0:ITER+1];
    logic [15:0]         r_cos;
    logic [W-1:0]        w_m;
    logic [W:0]          w_mr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ITER + 1; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= ITER + 1; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_item[0] <= i_item;
        for (int k = 1; k <= ITER + 1; k++) r_item[k] <= r_item[k-1];
        r_x[0] <= hal_pkg::CORDIC_START_X;
        r_y[0] <= '0;
        r_z[0] <= {{(W-32){i_p[15]}}, i_p, 16'h0000};
    end

    generate
        for (genvar k = 0; k < ITER; k++) begin : g_it
            logic signed [W-1:0] w_at;
            assign w_at = $signed({{(W-32){1'b0}}, hal_pkg::atan_turn(k)});

            always_ff @(posedge i_clk) begin
                if (!r_z[k][W-1]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - w_at;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + w_at;
                end
            end
        end
    endgenerate

    always_comb begin
        w_m  = r_x[ITER][W-1] ? W'(-r_x[ITER]) : W'(r_x[ITER]);
        w_mr = ((W+1)'(w_m) + (W+1)'(16384)) >> 15;
    end

    // round and clamp to unity
    always_ff @(posedge i_clk) begin
        r_cos <= (w_mr > (W+1)'(32768)) ? 16'h8000 : w_mr[15:0];
    end

    assign o_valid = r_v[ITER+1];
    assign o_item  = r_item[ITER+1];
    assign o_cos   = r_cos;

endmodule

>>> hdl/hal_isqrt.sv
module hal_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  hal_pkg::t_item               i_item,
    input  logic [hal_pkg::SQ_IN_W-1:0]  i_rad,
    output logic                         o_valid,
    output hal_pkg::t_item               o_item,
    output logic [hal_pkg::LEN_W-1:0]    o_root
);
    localparam int S  = hal_pkg::SQ_STEPS;
    localparam int IW = hal_pkg::SQ_IN_W;
    localparam int RW = hal_pkg::SQ_REM_W;

    logic [RW-1:0]  r_rem  [0:S-1];
    logic [S-1:0]   r_root [0:S-1];
    logic [IW-1:0]  r_rad  [0:S-1];
    logic           r_v    [0:S-1];
    hal_pkg::t_item r_item [0:S-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < S; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < S; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_item[0] <= i_item;
        for (int k = 1; k < S; k++) r_item[k] <= r_item[k-1];
    end

    generate
        for (genvar k = 0; k < S; k++) begin : g_st
            logic [RW-1:0] w_rem_in;
            logic [S-1:0]  w_root_in;
            logic [IW-1:0] w_rad_in;
            logic [RW+1:0] w_cur;
            logic [RW+1:0] w_trial;

            if (k == 0) begin : g_first
                assign w_rem_in  = '0;
                assign w_root_in = '0;
                assign w_rad_in  = i_rad;
            end else begin : g_next
                assign w_rem_in  = r_rem[k-1];
                assign w_root_in = r_root[k-1];
                assign w_rad_in  = r_rad[k-1];
            end

            assign w_cur   = {w_rem_in, w_rad_in[IW-1-2*k -: 2]};
            assign w_trial = (RW+2)'({w_root_in, 2'b01});

            always_ff @(posedge i_clk) begin
                r_rad[k] <= w_rad_in;
                if (w_cur >= w_trial) begin
                    r_rem[k]  <= RW'(w_cur - w_trial);
                    r_root[k] <= {w_root_in[S-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_cur[RW-1:0];
                    r_root[k] <= {w_root_in[S-2:0], 1'b0};
                end
            end
        end
    endgenerate

    assign o_valid = r_v[S-1];
    assign o_item  = r_item[S-1];
    assign o_root  = r_root[S-1];

endmodule

>>> hdl/hal_div.sv
module hal_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  hal_pkg::t_item             i_item,
    input  logic [hal_pkg::NUM_W-1:0]  i_num_a,
    input  logic [hal_pkg::NUM_W-1:0]  i_num_b,
    input  logic [hal_pkg::LEN_W-1:0]  i_den,
    output logic                       o_valid,
    output hal_pkg::t_item             o_item,
    output logic [hal_pkg::Q_W-1:0]    o_q_a,
    output logic [hal_pkg::Q_W-1:0]    o_q_b
);
    localparam int S  = hal_pkg::Q_W;
    localparam int NW = hal_pkg::NUM_W;
    localparam int DW = hal_pkg::LEN_W;

    logic [DW-1:0]  r_rem  [0:S-1][0:1];
    logic [S-1:0]   r_q    [0:S-1][0:1];
    logic [NW-1:0]  r_num  [0:S-1][0:1];
    logic [DW-1:0]  r_den  [0:S-1];
    logic           r_v    [0:S-1];
    hal_pkg::t_item r_item [0:S-1];
    logic [NW-1:0]  w_num  [0:1];

    assign w_num[0] = i_num_a;
    assign w_num[1] = i_num_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < S; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k < S; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_item[0] <= i_item;
        r_den[0]  <= i_den;
        for (int k = 1; k < S; k++) begin
            r_item[k] <= r_item[k-1];
            r_den[k]  <= r_den[k-1];
        end
    end

    generate
        for (genvar l = 0; l < 2; l++) begin : g_lane
            for (genvar k = 0; k < S; k++) begin : g_st
                logic [DW-1:0] w_rem_in;
                logic [S-1:0]  w_q_in;
                logic [NW-1:0] w_num_in;
                logic [DW-1:0] w_den_in;
                logic [DW:0]   w_cur;

                if (k == 0) begin : g_first
                    assign w_rem_in = DW'(w_num[l][NW-1:S]);
                    assign w_q_in   = '0;
                    assign w_num_in = w_num[l];
                    assign w_den_in = i_den;
                end else begin : g_next
                    assign w_rem_in = r_rem[k-1][l];
                    assign w_q_in   = r_q[k-1][l];
                    assign w_num_in = r_num[k-1][l];
                    assign w_den_in = r_den[k-1];
                end

                assign w_cur = {w_rem_in, w_num_in[S-1-k]};

                always_ff @(posedge i_clk) begin
                    r_num[k][l] <= w_num_in;
                    if (w_cur >= {1'b0, w_den_in}) begin
                        r_rem[k][l] <= DW'(w_cur - {1'b0, w_den_in});
                        r_q[k][l]   <= {w_q_in[S-2:0], 1'b1};
                    end else begin
                        r_rem[k][l] <= w_cur[DW-1:0];
                        r_q[k][l]   <= {w_q_in[S-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_v[S-1];
    assign o_item  = r_item[S-1];
    assign o_q_a   = r_q[S-1][0];
    assign o_q_b   = r_q[S-1][1];

endmodule

>>> hdl/heading_aware_acceleration_limiter_unit.sv
// channel   direction  handshake                      word
// command   in         i_start & !o_busy              target, previous velocity, heading
// result    out        o_valid strobe, one cycle      limited velocity, limit flag
// config    in         i_cfg_valid & o_cfg_ready      register index, limit value
//
// One word enters per cycle while o_busy is low; each result leaves through the two
// CORDIC pipelines, the 25-stage square root and the 16-stage divider. o_busy is high
// only during reset and the cycle after it.
// Synchronous reset clears all valid bits and the limit registers.
// Results are strobed and the receiver cannot stall, so the pipeline never holds.
`include "heading_aware_acceleration_limiter_unit_defines.svh"

module heading_aware_acceleration_limiter_unit #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [15:0] i_target_vx,
    input  logic signed [15:0] i_target_vy,
    input  logic signed [15:0] i_prev_vx,
    input  logic signed [15:0] i_prev_vy,
    input  logic signed [15:0] i_target_heading,
    output logic               o_valid,
    output logic signed [15:0] o_out_vx,
    output logic signed [15:0] o_out_vy,
    output logic               o_was_limited,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam int LATENCY = 2 * CORDIC_ITERATIONS + 54;

    logic r_busy;
    logic [14:0] r_sa, r_fa, r_sd, r_fd;

    hal_pkg::t_item r_s0, r_s1, r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7;
    hal_pkg::t_item n_s0, n_s1, n_p1, n_p2, n_p3, n_p4, n_p5, n_p6, n_p7;
    logic r_s0_v, r_s1_v, r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v, r_p6_v, r_p7_v;

    logic [30:0] r_pr0, r_pr1, r_pr2, r_pr3, r_pr4, r_pr5;
    logic [30:0] n_pr0, n_pr1, n_pr2, n_pr3, n_pr4, n_pr5;
    logic [14:0] r_acc, r_dec, n_acc, n_dec;
    logic [29:0] r_fin2, n_fin2;
    logic [hal_pkg::NUM_W-1:0] r_numx, r_numy, n_numx, n_numy;

    logic               r_out_v, r_out_lim, n_out_lim;
    logic signed [15:0] r_out_vx, r_out_vy, n_out_vx, n_out_vy;

    logic               w_vec_v, w_rot_v, w_sq_v, w_div_v;
    hal_pkg::t_item     w_vec_item, w_rot_item, w_sq_item, w_div_item;
    logic [15:0]        w_th_t, w_th_d, w_cos;
    logic [hal_pkg::LEN_W-1:0] w_len;
    logic [hal_pkg::Q_W-1:0]   w_qx, w_qy;

    logic [15:0]        w_angc, w_psi, w_na, w_nb, w_adx, w_ady;
    logic signed [33:0] w_sqx, w_sqy;
    logic [31:0]        w_sum0, w_sum1, w_sum2;
    logic signed [17:0] w_sx, w_sy;

    function automatic logic signed [15:0] sat18(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v[17:15] == 3'b000 || v[17:15] == 3'b111) r = v[15:0];
        else if (v[17]) r = 16'sh8000;
        else r = 16'sh7fff;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_sa   <= '0;
            r_fa   <= '0;
            r_sd   <= '0;
            r_fd   <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    hal_pkg::CFG_SIDE_ACC: r_sa <= i_cfg_data[14:0];
                    hal_pkg::CFG_FWD_ACC:  r_fa <= i_cfg_data[14:0];
                    hal_pkg::CFG_SIDE_DEC: r_sd <= i_cfg_data[14:0];
                    hal_pkg::CFG_FWD_DEC:  r_fd <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_cfg_ready = !r_busy;

    always_comb begin
        n_s0     = '0;
        n_s0.tx  = i_target_vx;
        n_s0.ty  = i_target_vy;
        n_s0.px  = i_prev_vx;
        n_s0.py  = i_prev_vy;
        n_s0.hd  = i_target_heading;
        n_s0.dx  = {i_target_vx[15], i_target_vx} - {i_prev_vx[15], i_prev_vx};
        n_s0.dy  = {i_target_vy[15], i_target_vy} - {i_prev_vy[15], i_prev_vy};

        // fold the heading error into the right half plane
        n_s1   = w_vec_item;
        w_angc = w_th_t - w_vec_item.hd;
        if ($signed(w_angc) > 16'sd16384 || $signed(w_angc) < -16'sd16384)
            n_s1.p = $signed(w_angc + 16'h8000);
        else
            n_s1.p = $signed(w_angc);
        w_psi  = w_th_d - w_th_t;
        n_s1.b = w_psi[15] ? (~w_psi + 16'd1) : w_psi;
        w_sqx  = w_vec_item.dx * w_vec_item.dx;
        w_sqy  = w_vec_item.dy * w_vec_item.dy;
        n_s1.sqx = w_sqx[31:0];
        n_s1.sqy = w_sqy[31:0];

        n_p1   = w_rot_item;
        n_p1.a = w_cos;
        n_p1.d2 = 33'(w_rot_item.sqx) + 33'(w_rot_item.sqy);
        w_na   = 16'(17'd32768 - {1'b0, w_cos});
        n_pr0  = 31'(r_sa) * 31'(w_na);
        n_pr1  = 31'(r_fa) * 31'(w_cos);
        n_pr2  = 31'(r_sd) * 31'(w_na);
        n_pr3  = 31'(r_fd) * 31'(w_cos);

        n_p2   = r_p1;
        w_sum0 = 32'(r_pr0) + 32'(r_pr1) + 32'd16384;
        w_sum1 = 32'(r_pr2) + 32'(r_pr3) + 32'd16384;
        n_acc  = w_sum0[29:15];
        n_dec  = w_sum1[29:15];

        n_p3   = r_p2;
        w_nb   = 16'(17'd32768 - {1'b0, r_p2.b});
        n_pr4  = 31'(r_acc) * 31'(w_nb);
        n_pr5  = 31'(r_dec) * 31'(r_p2.b);

        n_p4     = r_p3;
        w_sum2   = 32'(r_pr4) + 32'(r_pr5) + 32'd16384;
        n_p4.fin = w_sum2[29:15];

        n_p5     = r_p4;
        n_fin2   = 30'(r_p4.fin) * 30'(r_p4.fin);
        w_adx    = r_p4.dx[16] ? 16'(-r_p4.dx) : r_p4.dx[15:0];
        w_ady    = r_p4.dy[16] ? 16'(-r_p4.dy) : r_p4.dy[15:0];
        n_p5.magx = 31'(w_adx) * 31'(r_p4.fin);
        n_p5.magy = 31'(w_ady) * 31'(r_p4.fin);
        n_p5.d2z  = (r_p4.d2 == '0);

        n_p6      = r_p5;
        n_p6.pass = r_p5.d2 < 33'(r_fin2);

        n_p7      = w_sq_item;
        n_p7.len  = w_len;
        n_numx    = hal_pkg::NUM_W'({w_sq_item.magx, 8'h00})
                  + hal_pkg::NUM_W'(w_len[hal_pkg::LEN_W-1:1]);
        n_numy    = hal_pkg::NUM_W'({w_sq_item.magy, 8'h00})
                  + hal_pkg::NUM_W'(w_len[hal_pkg::LEN_W-1:1]);

        w_sx = {{2{w_div_item.px[15]}}, w_div_item.px}
             + (w_div_item.dx[16] ? -$signed({2'b00, w_qx}) : $signed({2'b00, w_qx}));
        w_sy = {{2{w_div_item.py[15]}}, w_div_item.py}
             + (w_div_item.dy[16] ? -$signed({2'b00, w_qy}) : $signed({2'b00, w_qy}));
        if (w_div_item.pass) begin
            n_out_vx  = w_div_item.tx;
            n_out_vy  = w_div_item.ty;
            n_out_lim = 1'b0;
        end else if (w_div_item.d2z) begin
            n_out_vx  = w_div_item.px;
            n_out_vy  = w_div_item.py;
            n_out_lim = 1'b1;
        end else begin
            n_out_vx  = sat18(w_sx);
            n_out_vy  = sat18(w_sy);
            n_out_lim = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_p4_v  <= 1'b0;
            r_p5_v  <= 1'b0;
            r_p6_v  <= 1'b0;
            r_p7_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s0_v  <= i_start && !r_busy;
            r_s1_v  <= w_vec_v;
            r_p1_v  <= w_rot_v;
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            r_p4_v  <= r_p3_v;
            r_p5_v  <= r_p4_v;
            r_p6_v  <= r_p5_v;
            r_p7_v  <= w_sq_v;
            r_out_v <= w_div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0      <= n_s0;
        r_s1      <= n_s1;
        r_p1      <= n_p1;
        r_pr0     <= n_pr0;
        r_pr1     <= n_pr1;
        r_pr2     <= n_pr2;
        r_pr3     <= n_pr3;
        r_p2      <= n_p2;
        r_acc     <= n_acc;
        r_dec     <= n_dec;
        r_p3      <= n_p3;
        r_pr4     <= n_pr4;
        r_pr5     <= n_pr5;
        r_p4      <= n_p4;
        r_p5      <= n_p5;
        r_fin2    <= n_fin2;
        r_p6      <= n_p6;
        r_p7      <= n_p7;
        r_numx    <= n_numx;
        r_numy    <= n_numy;
        r_out_vx  <= n_out_vx;
        r_out_vy  <= n_out_vy;
        r_out_lim <= n_out_lim;
    end

    hal_vec_cordic #(
        .ITER(CORDIC_ITERATIONS)
    ) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s0_v),
        .i_item  (r_s0),
        .i_ax    ({r_s0.tx[15], r_s0.tx}),
        .i_ay    ({r_s0.ty[15], r_s0.ty}),
        .i_bx    (r_s0.dx),
        .i_by    (r_s0.dy),
        .o_valid (w_vec_v),
        .o_item  (w_vec_item),
        .o_ang_a (w_th_t),
        .o_ang_b (w_th_d)
    );

    hal_rot_cordic #(
        .ITER(CORDIC_ITERATIONS)
    ) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_v),
        .i_item  (r_s1),
        .i_p     (r_s1.p),
        .o_valid (w_rot_v),
        .o_item  (w_rot_item),
        .o_cos   (w_cos)
    );

    hal_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p6_v),
        .i_item  (r_p6),
        .i_rad   ({1'b0, r_p6.d2, 16'h0000}),
        .o_valid (w_sq_v),
        .o_item  (w_sq_item),
        .o_root  (w_len)
    );

    hal_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p7_v),
        .i_item  (r_p7),
        .i_num_a (r_numx),
        .i_num_b (r_numy),
        .i_den   (r_p7.len),
        .o_valid (w_div_v),
        .o_item  (w_div_item),
        .o_q_a   (w_qx),
        .o_q_b   (w_qy)
    );

    assign o_valid       = r_out_v;
    assign o_out_vx      = r_out_vx;
    assign o_out_vy      = r_out_vy;
    assign o_was_limited = r_out_lim;

    `HAL_ASSERT_LAT(a_latency, i_clk, i_rst_n, r_s0_v, LATENCY, o_valid,
        "word did not leave after the pipeline latency")
    `HAL_ASSERT_IMP(a_qx_bound, i_clk, i_rst_n, w_div_v && !w_div_item.d2z,
        w_qx <= hal_pkg::Q_W'(w_div_item.fin), "scaled x step exceeds bound")
    `HAL_ASSERT_IMP(a_qy_bound, i_clk, i_rst_n, w_div_v && !w_div_item.d2z,
        w_qy <= hal_pkg::Q_W'(w_div_item.fin), "scaled y step exceeds bound")

endmodule

>>> test/heading_aware_acceleration_limiter_unit_checker.sv
module heading_aware_acceleration_limiter_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [15:0] i_target_vx,
    input  logic signed [15:0] i_target_vy,
    input  logic signed [15:0] i_prev_vx,
    input  logic signed [15:0] i_prev_vy,
    input  logic signed [15:0] i_target_heading,
    input  logic               i_valid,
    input  logic signed [15:0] i_out_vx,
    input  logic signed [15:0] i_out_vy,
    input  logic               i_was_limited,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_pending,
    output int                 o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITER = 16;

    typedef struct packed {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic               limited;
    } t_velocity;

    localparam bit [31:0] ATAN_TURN [0:15] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335086, 667544, 333772,
        166886, 83443, 41721, 20860
    };

    logic [14:0] side_acc, fwd_acc, side_dec, fwd_dec;
    t_velocity   velocity_q[$];
    int          errors;

    assign o_pending = velocity_q.size();
    assign o_errors  = errors;

    function automatic bit [15:0] bearing(input longint bx, input longint by);
        longint    x, y, nx, ny;
        bit [31:0] z;
        x = bx * 256;
        y = by * 256;
        z = 0;
        if (bx == 0 && by == 0) return 16'd0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < N_ITER; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_TURN[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_TURN[i];
            end
            x = nx;
            y = ny;
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    function automatic longint abs_cos(input bit [15:0] ang);
        int         p;
        bit [15:0]  folded;
        longint     x, y, z, nx, ny, m;
        p = $signed(ang);
        if (p > 16384 || p < -16384) begin
            folded = 16'(p + 32768);
            p = $signed(folded);
        end
        x = 652032874;
        y = 0;
        z = longint'(p) * 65536;
        for (int i = 0; i < N_ITER; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - longint'(ATAN_TURN[i]);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + longint'(ATAN_TURN[i]);
            end
            x = nx;
            y = ny;
        end
        m = (x < 0) ? -x : x;
        m = (m + 16384) >>> 15;
        return (m > 32768) ? 32768 : m;
    endfunction

    function automatic longint mix(input longint lo, input longint hi, input longint w);
        return (lo * (32768 - w) + hi * w + 16384) >>> 15;
    endfunction

    function automatic longint root(input longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] clip16(input longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic longint stretch(input longint d, input longint fin, input longint len);
        longint q;
        q = (((d < 0) ? -d : d) * fin * 256 + len / 2) / len;
        return (d < 0) ? -q : q;
    endfunction

    function automatic t_velocity limit_velocity(input logic signed [15:0] tx,
            input logic signed [15:0] ty, input logic signed [15:0] px,
            input logic signed [15:0] py, input logic [15:0] hd);
        longint    dx, dy, a, b, acc, dec, fin, d2, len;
        bit [15:0] th_t, th_d, diff;
        int        psi;
        t_velocity r;
        dx   = longint'(tx) - longint'(px);
        dy   = longint'(ty) - longint'(py);
        th_t = bearing(tx, ty);
        th_d = bearing(dx, dy);
        a    = abs_cos(th_t - hd);
        diff = th_d - th_t;
        psi  = $signed(diff);
        b    = (psi < 0) ? -psi : psi;
        acc  = mix(side_acc, fwd_acc, a);
        dec  = mix(side_dec, fwd_dec, a);
        fin  = mix(acc, dec, b);
        d2   = dx * dx + dy * dy;
        if (d2 < fin * fin) begin
            r.vx = tx;
            r.vy = ty;
            r.limited = 1'b0;
        end else if (d2 == 0) begin
            r.vx = px;
            r.vy = py;
            r.limited = 1'b1;
        end else begin
            len  = root(d2 << 16);
            r.vx = clip16(longint'(px) + stretch(dx, fin, len));
            r.vy = clip16(longint'(py) + stretch(dy, fin, len));
            r.limited = 1'b1;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_velocity want;
        if (!i_rst_n) begin
            side_acc <= '0;
            fwd_acc  <= '0;
            side_dec <= '0;
            fwd_dec  <= '0;
        end else if (i_cfg_valid && i_cfg_ready) begin
            case (i_cfg_index)
                hal_pkg::CFG_SIDE_ACC: side_acc <= i_cfg_data[14:0];
                hal_pkg::CFG_FWD_ACC:  fwd_acc  <= i_cfg_data[14:0];
                hal_pkg::CFG_SIDE_DEC: side_dec <= i_cfg_data[14:0];
                hal_pkg::CFG_FWD_DEC:  fwd_dec  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
        if (i_rst_n && i_valid) begin
            if (velocity_q.size() == 0) begin
                $display("%t unexpected word: vx %0d vy %0d lim %0b", $realtime,
                         i_out_vx, i_out_vy, i_was_limited);
                errors++;
            end else begin
                want = velocity_q.pop_front();
                if (want.vx !== i_out_vx) begin
                    $display("%t out_vx expected %0d actual %0d", $realtime, want.vx, i_out_vx);
                    errors++;
                end
                if (want.vy !== i_out_vy) begin
                    $display("%t out_vy expected %0d actual %0d", $realtime, want.vy, i_out_vy);
                    errors++;
                end
                if (want.limited !== i_was_limited) begin
                    $display("%t was_limited expected %0b actual %0b", $realtime,
                             want.limited, i_was_limited);
                    errors++;
                end
            end
        end
        if (i_rst_n && i_start && !i_busy)
            velocity_q.push_back(limit_velocity(i_target_vx, i_target_vy, i_prev_vx,
                                                i_prev_vy, i_target_heading));
    end

    initial errors = 0;
endmodule

>>> test/heading_aware_acceleration_limiter_unit_tb.sv
module heading_aware_acceleration_limiter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 3000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic signed [15:0] i_target_vx = '0, i_target_vy = '0;
    logic signed [15:0] i_prev_vx = '0, i_prev_vy = '0, i_target_heading = '0;
    logic               o_valid, o_was_limited;
    logic signed [15:0] o_out_vx, o_out_vy;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    int                 pending, errors, quiet;
    bit                 calm;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    heading_aware_acceleration_limiter_unit u_dut (.*);

    heading_aware_acceleration_limiter_unit_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy),
        .i_target_vx, .i_target_vy, .i_prev_vx, .i_prev_vy, .i_target_heading,
        .i_valid(o_valid), .i_out_vx(o_out_vx), .i_out_vy(o_out_vy),
        .i_was_limited(o_was_limited), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_pending(pending), .o_errors(errors)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        bit rdy;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending != 0 || i_start) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [15:0] sa, input logic [15:0] fa,
                              input logic [15:0] sd, input logic [15:0] fd);
        write_reg(hal_pkg::CFG_SIDE_ACC, sa);
        write_reg(hal_pkg::CFG_FWD_ACC, fa);
        write_reg(hal_pkg::CFG_SIDE_DEC, sd);
        write_reg(hal_pkg::CFG_FWD_DEC, fd);
    endtask

    task automatic send(input logic [15:0] tx, input logic [15:0] ty,
                        input logic [15:0] px, input logic [15:0] py, input logic [15:0] hd);
        bit bsy;
        i_start          <= 1'b1;
        i_target_vx      <= tx;
        i_target_vy      <= ty;
        i_prev_vx        <= px;
        i_prev_vy        <= py;
        i_target_heading <= hd;
        do begin
            @(negedge i_clk);
            bsy = o_busy;
            @(posedge i_clk);
        end while (bsy);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic finish_burst();
        i_start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_word();
        logic [15:0] tx, ty, px, py;
        tx = 16'($urandom);
        ty = 16'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                px = 16'($urandom);
                py = 16'($urandom);
            end
            1: begin
                px = tx + $signed(16'($urandom_range(0, 64)) - 16'sd32);
                py = ty + $signed(16'($urandom_range(0, 64)) - 16'sd32);
            end
            2: begin
                px = tx + $signed(16'($urandom_range(0, 8192)) - 16'sd4096);
                py = ty + $signed(16'($urandom_range(0, 8192)) - 16'sd4096);
            end
            default: begin
                px = tx;
                py = ty;
            end
        endcase
        send(tx, ty, px, py, 16'($urandom));
    endtask

    initial begin
        calm = 1'b0;
        quiet = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero delta with zero bound, then a full-scale delta
        send(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send(16'h1000, 16'hF000, 16'h1000, 16'hF000, 16'h4000);
        send(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
        finish_burst();
        wait_drained();
        set_limits(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        write_reg(8'd4, 16'h1234);
        write_reg(8'hFF, 16'h0000);
        send(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send(16'h7FFF, 16'h0000, 16'h7000, 16'h0000, 16'h0000);
        send(16'h0000, 16'h0000, 16'h0010, 16'hFFF0, 16'h2000);
        send(16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'hC000);
        finish_burst();
        wait_drained();
        set_limits(16'h0100, 16'h0800, 16'h0040, 16'h0400);
        send(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000);
        send(16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000);
        send(16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send(16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send(16'h0000, 16'h2000, 16'h0000, 16'h4000, 16'hC000);
        send(16'h0000, 16'h0000, 16'h1000, 16'h1000, 16'h0000);
        send(16'h0010, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        finish_burst();

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            case (ph)
                0: set_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                1: set_limits(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
                2: set_limits(16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000);
                default: set_limits(16'($urandom_range(0, 16'h2000)), 16'($urandom),
                                    16'($urandom_range(0, 16'h1000)), 16'($urandom));
            endcase
            write_reg(8'($urandom_range(4, 255)), 16'($urandom));
            for (int n = 0; n < 215; n++) begin
                calm = (ph == 5 && n >= 15);
                random_word();
            end
            finish_burst();
        end

        wait_drained();
        repeat (120) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
